FILE: rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the stereo sample player
// Request formats, frame store word, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package ssp_pkg;

	// Store geometry and sample format
	localparam int FRAMES     = 4096;
	localparam int ADDR_W     = 12;
	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 13;
	localparam int RATIO_W    = 16;
	localparam int START_W    = 16;

	// Phase: PFB fraction bits. The phase can run well past the span after a
	// shorter length is written in loop mode, so it is kept wide.
	localparam int PFB        = 16;
	localparam int PHASE_W    = 48;
	localparam int RESTART_W  = ADDR_W + START_W;

	// Step = rate(Q4.12) * ratio(Q4.12) >> (24 - PFB)
	localparam int RATE_PROD_W = 33;
	localparam int STEP_SHIFT  = 24 - PFB;
	localparam int STEP_W      = RATE_PROD_W - STEP_SHIFT;

	// Interpolation product: 17-bit difference times unsigned fraction
	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int LERP_W     = DIFF_W + PFB + 1;

	// Trigger threshold, 0.5 in Q1.15
	localparam logic signed [SAMPLE_W-1:0] TRIG_LEVEL = 16'sd16384;

	// Commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LENGTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_RATIO        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_CONNECTED = 2'd3;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd4096;

	typedef struct packed {
		logic                        command;
		logic [ADDR_W-1:0]           frame_index;
		logic signed [SAMPLE_W-1:0]  frame_left;
		logic signed [SAMPLE_W-1:0]  frame_right;
		logic                        load_last;
		logic signed [SAMPLE_W-1:0]  trigger_level;
		logic signed [SAMPLE_W-1:0]  play_rate;
		logic [START_W-1:0]          start_pos;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
		logic                       is_playing;
	} out_item_t;

	// One stereo frame as stored
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} frame_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		frame_t            data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	// Per-tick control from the phase stage to the interpolator
	typedef struct packed {
		logic           audible;
		logic [PFB-1:0] frac;
		logic           playing;
	} tick_info_t;

endpackage

FILE: rtl/stereo_sample_player.sv
// ----------------------------------------------------------------------------
// stereo_sample_player: looping/one-shot stereo sample player
// Loads frames into a store and plays them back with linear interpolation.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | carries
//  --------+----------------------------------+-----------+-------------------------
//  in      | in_valid, in_ready, in_data      | into      | load or tick request
//  cfg     | cfg_valid, cfg_ready, cfg_index, | into      | register write
//          | cfg_data                         |           |
//  out     | out_valid, out_ready, out_data   | out of    | one result per tick
//
//  One request per cycle unless a tick held in the request stage waits for
//  room downstream. The phase stage updates phase, playing flag and trigger
//  history once per request; the store reads two frames through its two read
//  ports. A tick passes the request register, the store read, stage 3 and the
//  result register. Reset clears the playback state and registers; the frame
//  store holds no reset. A stalled output backs up through the stages; a load
//  still retires from the request stage unless a tick is held there.
// ----------------------------------------------------------------------------
module stereo_sample_player (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ssp_pkg::in_item_t               in_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ssp_pkg::out_item_t              out_data
);

	ssp_pkg::mem_wr_t    mem_wr;
	ssp_pkg::mem_rd_t    mem_rd;
	ssp_pkg::frame_t     rd_a;
	ssp_pkg::frame_t     rd_b;
	logic                s2_ready;
	logic                tick_valid;
	ssp_pkg::tick_info_t tick_info;

	// Configuration, loads and phase state
	ssp_phase_ctrl u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s2_ready   (s2_ready),
		.mem_wr     (mem_wr),
		.mem_rd     (mem_rd),
		.tick_valid (tick_valid),
		.tick_info  (tick_info)
	);

	// Frame store
	ssp_frame_mem u_mem (
		.clk  (clk),
		.wr   (mem_wr),
		.rd   (mem_rd),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	// Interpolation and result register
	ssp_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_info  (tick_info),
		.s2_ready   (s2_ready),
		.rd_a       (rd_a),
		.rd_b       (rd_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

FILE: rtl/ssp_frame_mem.sv
// ----------------------------------------------------------------------------
// ssp_frame_mem: stereo frame store
// One write port, two registered read ports at addr and addr+1.
// ----------------------------------------------------------------------------
module ssp_frame_mem (
	input  logic             clk,
	input  ssp_pkg::mem_wr_t wr,
	input  ssp_pkg::mem_rd_t rd,
	output ssp_pkg::frame_t  rd_a,
	output ssp_pkg::frame_t  rd_b
);

	ssp_pkg::frame_t mem [ssp_pkg::FRAMES];
	logic [ssp_pkg::ADDR_W-1:0] addr_nxt;

	assign addr_nxt = rd.addr + ssp_pkg::ADDR_W'(1);

	// Write and paired read; read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_a <= mem[rd.addr];
			rd_b <= mem[addr_nxt];
		end
	end

endmodule

FILE: rtl/ssp_phase_ctrl.sv
// ----------------------------------------------------------------------------
// ssp_phase_ctrl: configuration, request register and playback state
// Executes loads and advances phase, playing and trigger history per tick.
// ----------------------------------------------------------------------------
module ssp_phase_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ssp_pkg::in_item_t                   in_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ssp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ssp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s2_ready,
	output ssp_pkg::mem_wr_t                    mem_wr,
	output ssp_pkg::mem_rd_t                    mem_rd,
	output logic                                tick_valid,
	output ssp_pkg::tick_info_t                 tick_info
);

	localparam int AW  = ssp_pkg::ADDR_W;
	localparam int PW  = ssp_pkg::PHASE_W;
	localparam int PFB = ssp_pkg::PFB;

	// Configuration registers (length kept as span = saturated length - 1)
	logic                           loop_q;
	logic [ssp_pkg::RATIO_W-1:0]    ratio_q;
	logic                           trig_conn_q;
	logic [AW-1:0]                  span_q;
	logic                           len_ok_q;

	// Playback state
	logic signed [PW-1:0]           phase_q;
	logic                           playing_q;
	logic                           prev_trig_q;

	// Stage 1 request register
	logic                           v1_q;
	logic                           cmd_s1;
	logic [AW-1:0]                  idx_s1;
	ssp_pkg::frame_t                frame_s1;
	logic                           last_s1;
	logic                           trig_high_s1;
	logic [ssp_pkg::RESTART_W-1:0]  restart_s1;
	logic signed [ssp_pkg::STEP_W-1:0] step_s1;

	logic [ssp_pkg::LEN_W-1:0]      cfg_len;
	logic [ssp_pkg::LEN_W-1:0]      cfg_len_sat;
	logic [ssp_pkg::RESTART_W-1:0]  restart_c;
	logic signed [ssp_pkg::RATE_PROD_W-1:0] rate_prod_c;

	logic                           adv1;
	logic                           fire1;
	logic                           rise;
	logic                           play_base;
	logic signed [PW-1:0]           base;
	logic signed [PW-1:0]           step_ext;
	logic signed [PW-1:0]           span_p;
	logic signed [PW-1:0]           nxt;
	logic signed [PW-1:0]           nxt_hi;
	logic signed [PW-1:0]           nxt_lo;
	logic                           base_over;
	logic                           nxt_over;
	logic [AW-1:0]                  rd_addr;
	logic [PFB-1:0]                 rd_frac;
	logic signed [PW-1:0]           phase_d;
	logic                           play_d;
	logic                           prev_d;

	// Configuration port: always ready; writes must land only while idle, which the block itself does not enforce
	assign cfg_ready   = 1'b1;
	assign cfg_len     = cfg_data[ssp_pkg::LEN_W-1:0];
	assign cfg_len_sat = (cfg_len > ssp_pkg::LEN_W'(ssp_pkg::FRAMES)) ?
		ssp_pkg::LEN_W'(ssp_pkg::FRAMES) : cfg_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q      <= 1'b0;
			ratio_q     <= ssp_pkg::RATIO_RESET;
			trig_conn_q <= 1'b0;
			span_q      <= '0;
			len_ok_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ssp_pkg::REG_SAMPLE_LENGTH: begin
					len_ok_q <= (cfg_len >= ssp_pkg::LEN_W'(2));
					span_q   <= AW'(cfg_len_sat - ssp_pkg::LEN_W'(1));
				end
				ssp_pkg::REG_LOOP_MODE:         loop_q      <= cfg_data[0];
				ssp_pkg::REG_RATE_RATIO:        ratio_q     <= cfg_data[ssp_pkg::RATIO_W-1:0];
				ssp_pkg::REG_TRIGGER_CONNECTED: trig_conn_q <= cfg_data[0];
			endcase
		end
	end

	// Request handshake: a load always retires, a tick needs room downstream
	assign adv1     = ~v1_q | (cmd_s1 == ssp_pkg::CMD_LOAD) | s2_ready;
	assign in_ready = adv1;
	assign fire1    = v1_q & adv1;

	// Products formed on accept: restart point and phase step.
	// With PFB equal to the start_pos fraction width the restart phase is the
	// plain product. A 16-bit rate already lies inside +/-8.0.
	assign restart_c   = ssp_pkg::RESTART_W'(in_data.start_pos) * ssp_pkg::RESTART_W'(span_q);
	assign rate_prod_c = in_data.play_rate * $signed({1'b0, ratio_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (adv1) begin
			v1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv1) begin
			cmd_s1       <= in_data.command;
			idx_s1       <= in_data.frame_index;
			frame_s1     <= '{left: in_data.frame_left, right: in_data.frame_right};
			last_s1      <= in_data.load_last;
			trig_high_s1 <= (in_data.trigger_level > ssp_pkg::TRIG_LEVEL);
			restart_s1   <= restart_c;
			step_s1      <= ssp_pkg::STEP_W'(rate_prod_c >>> ssp_pkg::STEP_SHIFT);
		end
	end

	// Trigger edge and phase to read at
	assign rise      = trig_high_s1 & ~prev_trig_q;
	assign play_base = rise | playing_q;
	assign base      = rise ? $signed({{(PW-ssp_pkg::RESTART_W){1'b0}}, restart_s1}) : phase_q;
	assign span_p    = $signed({{(PW-AW-PFB){1'b0}}, span_q, {PFB{1'b0}}});
	assign base_over = (base >= span_p);

	// Read position saturated into [0, span_p - 1]
	always_comb begin
		if (base[PW-1]) begin
			rd_addr = '0;
			rd_frac = '0;
		end else if (base_over) begin
			rd_addr = span_q - AW'(1);
			rd_frac = '1;
		end else begin
			rd_addr = base[PFB+AW-1:PFB];
			rd_frac = base[PFB-1:0];
		end
	end

	// Phase advance with single wrap at either end
	assign step_ext = PW'(step_s1);
	assign nxt      = base + step_ext;
	assign nxt_hi   = nxt - span_p;
	assign nxt_lo   = nxt + span_p;
	assign nxt_over = (nxt >= span_p);

	always_comb begin
		phase_d = phase_q;
		play_d  = playing_q;
		prev_d  = prev_trig_q;
		if (fire1) begin
			if (cmd_s1 == ssp_pkg::CMD_LOAD) begin
				if (last_s1) begin
					phase_d = '0;
					play_d  = loop_q | ~trig_conn_q;
				end
			end else if (len_ok_q) begin
				prev_d  = trig_high_s1;
				play_d  = play_base;
				phase_d = base;
				if (play_base) begin
					phase_d = nxt;
					priority if (nxt_over) begin
						if (loop_q) phase_d = nxt_hi;
						else        play_d  = 1'b0;
					end else if (nxt[PW-1]) begin
						if (loop_q) phase_d = nxt_lo;
						else        play_d  = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			playing_q   <= 1'b0;
			prev_trig_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			playing_q   <= play_d;
			prev_trig_q <= prev_d;
		end
	end

	// Store access; every 12-bit index lies inside the store
	assign mem_wr.en   = fire1 & (cmd_s1 == ssp_pkg::CMD_LOAD);
	assign mem_wr.addr = idx_s1;
	assign mem_wr.data = frame_s1;

	assign tick_valid  = v1_q & (cmd_s1 == ssp_pkg::CMD_TICK);
	assign mem_rd.en   = tick_valid & s2_ready;
	assign mem_rd.addr = rd_addr;

	assign tick_info.audible = len_ok_q & play_base;
	assign tick_info.frac    = rd_frac;
	assign tick_info.playing = play_d;

endmodule

FILE: rtl/ssp_interp.sv
// ----------------------------------------------------------------------------
// ssp_interp: linear interpolation and result register
// Difference times fraction, then add back the first frame.
// ----------------------------------------------------------------------------
module ssp_interp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	input  ssp_pkg::tick_info_t  tick_info,
	output logic                 s2_ready,
	input  ssp_pkg::frame_t      rd_a,
	input  ssp_pkg::frame_t      rd_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ssp_pkg::out_item_t   out_data
);

	localparam int SW  = ssp_pkg::SAMPLE_W;
	localparam int DW  = ssp_pkg::DIFF_W;
	localparam int LW  = ssp_pkg::LERP_W;
	localparam int PFB = ssp_pkg::PFB;

	logic                 v2_q;
	ssp_pkg::tick_info_t  info_s2;
	logic                 v3_q;
	logic                 aud_s3;
	logic                 play_s3;
	ssp_pkg::frame_t      a_s3;
	logic signed [LW-1:0] pl_s3;
	logic signed [LW-1:0] pr_s3;
	logic                 out_valid_q;
	ssp_pkg::out_item_t   out_q;

	logic                 out_en;
	logic                 adv3;
	logic signed [DW-1:0] dl;
	logic signed [DW-1:0] dr;
	logic signed [LW-1:0] pl;
	logic signed [LW-1:0] pr;
	logic signed [LW-1:0] sum_l;
	logic signed [LW-1:0] sum_r;

	// Stage enables
	assign out_en   = ~out_valid_q | out_ready;
	assign adv3     = ~v3_q | out_en;
	assign s2_ready = ~v2_q | adv3;

	// Stage 2: frame data arrives from the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (s2_ready) begin
			v2_q <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && tick_valid) begin
			info_s2 <= tick_info;
		end
	end

	// Difference times fraction per channel
	assign dl = DW'(rd_b.left)  - DW'(rd_a.left);
	assign dr = DW'(rd_b.right) - DW'(rd_a.right);
	assign pl = dl * $signed({1'b0, info_s2.frac});
	assign pr = dr * $signed({1'b0, info_s2.frac});

	// Stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (adv3) begin
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v2_q) begin
			aud_s3  <= info_s2.audible;
			play_s3 <= info_s2.playing;
			a_s3    <= rd_a;
			pl_s3   <= pl;
			pr_s3   <= pr;
		end
	end

	// a + floor(diff * frac / 2^PFB); result stays between the two frames
	assign sum_l = (pl_s3 >>> PFB) + LW'(a_s3.left);
	assign sum_r = (pr_s3 >>> PFB) + LW'(a_s3.right);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && v3_q) begin
			out_q.out_left   <= aud_s3 ? sum_l[SW-1:0] : '0;
			out_q.out_right  <= aud_s3 ? sum_r[SW-1:0] : '0;
			out_q.is_playing <= play_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
